### rtl/core/adaptive_beacon_interval_scheduler_macros.svh
// Assertion macros shared by the checker of the beacon interval scheduler.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ADAPTIVE_BEACON_INTERVAL_SCHEDULER_MACROS_SVH
`define ADAPTIVE_BEACON_INTERVAL_SCHEDULER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ABIS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ABIS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ABIS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/abis_pkg.sv
// Package of the beacon interval scheduler: widths, op and register codes,
// reset values, and the structs passed between modules. Depends on nothing.
package abis_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PROD_W     = TIME_W + 10;   // ttl * 1000 fits here

    localparam int unsigned S_DATA_W = 64;   // now_ms, sleep length
    localparam int unsigned S_USER_W = 8;    // op, zero filled to a byte
    localparam int unsigned M_DATA_W = 88;   // 84 result bits, zero filled

    localparam int unsigned MS_PER_S = 1000;

    localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;
    localparam logic [TIME_W-1:0]  WIN_DEFAULT = TIME_W'(1000);
    localparam logic [LEVEL_W-1:0] THR_MIN     = LEVEL_W'(1);

    // Register reset values and what a start derives from them.
    localparam int unsigned TTL_RESET_S = 120;
    localparam logic [TIME_W-1:0]  MAX_RESET  = TIME_W'(60000);
    localparam logic [LEVEL_W-1:0] HC_RESET   = LEVEL_W'(50);
    localparam logic [TIME_W-1:0]  BASE_RESET = TIME_W'(TTL_RESET_S * 500);
    localparam logic [TIME_W-1:0]  SAFE_RESET =
        TIME_W'(TTL_RESET_S * MS_PER_S - (TTL_RESET_S * MS_PER_S) / 8);

    typedef enum logic [OP_W-1:0] {
        OP_START = 3'd0,
        OP_FRAME = 3'd1,
        OP_TICK  = 3'd2,
        OP_STOP  = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TTL             = 2'd0,
        CFG_MAX_INTERVAL    = 2'd1,
        CFG_HIGH_CONTENTION = 2'd2,
        CFG_WINDOW_LENGTH   = 2'd3
    } t_cfg_idx;

    // Values a start loads, already derived from the registers.
    typedef struct packed {
        logic [TIME_W-1:0]  floor_ms;
        logic [TIME_W-1:0]  ceiling_ms;
        logic [LEVEL_W-1:0] threshold;
        logic [TIME_W-1:0]  window_len;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  announce_total;
        logic [LEVEL_W-1:0] contention_level;
        logic [TIME_W-1:0]  interval_now;
        logic               lapse_before_wake;
        logic               window_closed;
        logic               announce;
        logic               accepted;
    } t_result;

endpackage

### rtl/core/abis_cfg.sv
// Configuration registers of the beacon interval scheduler and the interval
// bounds derived from them. Depends on abis_pkg.
module abis_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [abis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output abis_pkg::t_cfg                 o_cfg
);
    import abis_pkg::*;

    logic [PROD_W-1:0]  w_ttl_ms;
    logic [PROD_W-1:0]  w_half;
    logic [PROD_W-1:0]  w_safe;
    logic [TIME_W-1:0]  w_base_sat;
    logic [TIME_W-1:0]  w_safe_sat;
    logic [TIME_W-1:0]  w_ceil_min;
    logic [TIME_W-1:0]  n_ceil;

    logic [TIME_W-1:0]  r_base;
    logic [TIME_W-1:0]  r_safe;
    logic [TIME_W-1:0]  r_max;
    logic [LEVEL_W-1:0] r_thr;
    logic [TIME_W-1:0]  r_win;
    logic [TIME_W-1:0]  r_ceil;

    // Saturate both products to 32 bits as they are written.
    always_comb begin
        w_ttl_ms   = PROD_W'(i_cfg_data) * PROD_W'(MS_PER_S);
        w_half     = w_ttl_ms >> 1;
        w_safe     = w_ttl_ms - (w_ttl_ms >> 3);
        w_base_sat = (|w_half[PROD_W-1:TIME_W]) ? TIME_MAX : w_half[TIME_W-1:0];
        w_safe_sat = (|w_safe[PROD_W-1:TIME_W]) ? TIME_MAX : w_safe[TIME_W-1:0];
    end

    // Ceiling: min of requested and safe, raised to at least the base.
    always_comb begin
        w_ceil_min = (r_max < r_safe) ? r_max : r_safe;
        n_ceil     = (w_ceil_min < r_base) ? r_base : w_ceil_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_safe <= SAFE_RESET;
            r_max  <= MAX_RESET;
            r_thr  <= HC_RESET;
            r_win  <= WIN_DEFAULT;
            r_ceil <= MAX_RESET;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TTL: begin
                        r_base <= w_base_sat;
                        r_safe <= w_safe_sat;
                    end
                    CFG_MAX_INTERVAL: begin
                        r_max <= i_cfg_data[TIME_W-1:0];
                    end
                    CFG_HIGH_CONTENTION: begin
                        r_thr <= (i_cfg_data[LEVEL_W-1:0] == '0) ? THR_MIN
                                                                 : i_cfg_data[LEVEL_W-1:0];
                    end
                    CFG_WINDOW_LENGTH: begin
                        r_win <= (i_cfg_data[TIME_W-1:0] == '0) ? WIN_DEFAULT
                                                                : i_cfg_data[TIME_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_ceil <= n_ceil;
        end
    end

    assign o_cfg.floor_ms   = r_base;
    assign o_cfg.ceiling_ms = r_ceil;
    assign o_cfg.threshold  = r_thr;
    assign o_cfg.window_len = r_win;

endmodule

### rtl/core/abis_core.sv
// Scheduler state and the single-pass update for one operation.
// Depends on abis_pkg; fed by abis_cfg and the top level's input register.
module abis_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  abis_pkg::t_op               i_op,
    input  logic [abis_pkg::TIME_W-1:0] i_now_ms,
    input  logic [abis_pkg::TIME_W-1:0] i_sleep_len,
    input  abis_pkg::t_cfg              i_cfg,
    output abis_pkg::t_result           o_result
);
    import abis_pkg::*;

    logic               r_active,  n_active;
    logic [TIME_W-1:0]  r_cur,     n_cur;
    logic [TIME_W-1:0]  r_floor,   n_floor;
    logic [TIME_W-1:0]  r_ceil,    n_ceil;
    logic [LEVEL_W-1:0] r_thr,     n_thr;
    logic [TIME_W-1:0]  r_win,     n_win;
    logic [TIME_W-1:0]  r_frames,  n_frames;
    logic [TIME_W-1:0]  r_wsc,     n_wsc;
    logic [TIME_W-1:0]  r_wst,     n_wst;
    logic [TIME_W-1:0]  r_lat,     n_lat;
    logic [LEVEL_W-1:0] r_level,   n_level;
    logic [TIME_W-1:0]  r_count,   n_count;

    logic [TIME_W-1:0]  w_win_elapsed;
    logic [TIME_W-1:0]  w_delta;
    logic [LEVEL_W-1:0] w_lvl;
    logic [TIME_W-1:0]  w_up;
    logic [TIME_W-1:0]  w_down;
    logic [TIME_W-1:0]  w_adapted;
    logic               w_closing;
    logic [TIME_W-1:0]  w_interval_after;
    logic [TIME_W:0]    w_lapse_sum;

    // Contention level of the window and the interval it would move to.
    always_comb begin
        w_win_elapsed = i_now_ms - r_wst;
        w_delta       = r_frames - r_wsc;
        w_lvl         = (|w_delta[TIME_W-1:LEVEL_W]) ? LEVEL_MAX : w_delta[LEVEL_W-1:0];
        w_up          = {r_cur[TIME_W-2:0], 1'b0};
        if (r_cur[TIME_W-1] || (w_up > r_ceil)) begin
            w_up = r_ceil;
        end
        w_down = r_cur >> 1;
        if (w_down < r_floor) begin
            w_down = r_floor;
        end
        if (w_lvl >= r_thr) begin
            w_adapted = w_up;
        end else if (w_lvl == '0) begin
            w_adapted = w_down;
        end else begin
            w_adapted = r_cur;
        end
        w_closing        = (w_win_elapsed >= r_win);
        w_interval_after = w_closing ? w_adapted : r_cur;
        w_lapse_sum      = {1'b0, i_now_ms - r_lat} + {1'b0, i_sleep_len};
    end

    always_comb begin
        n_active = r_active;
        n_cur    = r_cur;
        n_floor  = r_floor;
        n_ceil   = r_ceil;
        n_thr    = r_thr;
        n_win    = r_win;
        n_frames = r_frames;
        n_wsc    = r_wsc;
        n_wst    = r_wst;
        n_lat    = r_lat;
        n_level  = r_level;
        n_count  = r_count;
        o_result = '0;

        case (i_op)
            OP_START: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_floor  = i_cfg.floor_ms;
                    n_ceil   = i_cfg.ceiling_ms;
                    n_cur    = i_cfg.floor_ms;
                    n_thr    = i_cfg.threshold;
                    n_win    = i_cfg.window_len;
                    n_frames = '0;
                    n_wsc    = '0;
                    n_wst    = i_now_ms;
                    n_lat    = i_now_ms;
                    n_level  = '0;
                    n_count  = '0;
                    o_result.accepted = 1'b1;
                end
            end
            OP_FRAME: begin
                if (r_active) begin
                    n_frames = r_frames + TIME_W'(1);
                    o_result.accepted = 1'b1;
                end
            end
            OP_TICK: begin
                if (r_active) begin
                    o_result.accepted = 1'b1;
                    if (w_closing) begin
                        n_wsc   = r_frames;
                        n_wst   = i_now_ms;
                        n_level = w_lvl;
                        n_cur   = w_adapted;
                        o_result.window_closed = 1'b1;
                    end
                    // Announce against the interval as this tick leaves it.
                    if ((i_now_ms - r_lat) >= w_interval_after) begin
                        n_lat   = i_now_ms;
                        n_count = r_count + TIME_W'(1);
                        o_result.announce = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                if (r_active) begin
                    n_active = 1'b0;
                    o_result.accepted = 1'b1;
                end
            end
            OP_QUERY: begin
                o_result.accepted          = 1'b1;
                o_result.lapse_before_wake = (w_lapse_sum >= {1'b0, r_cur});
            end
            default: begin
            end
        endcase

        o_result.interval_now     = n_cur;
        o_result.contention_level = n_level;
        o_result.announce_total   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cur    <= '0;
            r_floor  <= '0;
            r_ceil   <= '0;
            r_thr    <= THR_MIN;
            r_win    <= WIN_DEFAULT;
            r_frames <= '0;
            r_wsc    <= '0;
            r_wst    <= '0;
            r_lat    <= '0;
            r_level  <= '0;
            r_count  <= '0;
        end else if (i_advance) begin
            r_active <= n_active;
            r_cur    <= n_cur;
            r_floor  <= n_floor;
            r_ceil   <= n_ceil;
            r_thr    <= n_thr;
            r_win    <= n_win;
            r_frames <= n_frames;
            r_wsc    <= n_wsc;
            r_wst    <= n_wst;
            r_lat    <= n_lat;
            r_level  <= n_level;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/core/adaptive_beacon_interval_scheduler.sv
// Top level of the adaptive beacon interval scheduler: input register,
// output register and stream handshakes. Depends on abis_pkg, abis_cfg, abis_core.
//
// Usage:
//   Slave stream carries one operation per transfer: tuser holds the op code
//   (0 start, 1 frame seen, 2 tick, 3 stop, 4 pre-sleep query), tdata holds
//   now_ms and the planned sleep length. Every operation yields exactly one
//   result transfer on the master stream, in order, with the flags, current
//   interval, contention level of the last closed window and the announce count.
//   Configuration registers (0 ttl, 1 max interval, 2 high contention,
//   3 window length) are written through i_cfg_we/i_cfg_index/i_cfg_data
//   while the block is idle; they take effect at the next start.
// Path: an operation taken from the slave stream sits in the input register, is
//   evaluated in one pass against the scheduler state once the output register
//   is free or being emptied, and lands there for the master side to take.
// Throughput: one operation per cycle unless stalled, set by the single-pass update
//   (window compare, clamp of the doubled or halved interval, announce compare).
// Reset (synchronous, active low): both stages empty, scheduler stopped,
//   registers back to ttl 120 s, max 60000 ms, threshold 50, window 1000 ms.
// Stall: while the master side holds tready low, the result waits in the
//   output register, one more operation waits in the input register, and
//   then the slave side's tready drops.
module adaptive_beacon_interval_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [abis_pkg::S_DATA_W-1:0]   i_s_axis_tdata,  // [31:0] now_ms, [63:32] sleep length
    input  logic [abis_pkg::S_USER_W-1:0]   i_s_axis_tuser,  // [2:0] op, [7:3] zero
    // master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] accepted, [1] announce, [2] window_closed, [3] lapse_before_wake,
    // [35:4] interval_now, [51:36] contention_level, [83:52] announce_total,
    // [87:84] zero
    output logic [abis_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [abis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import abis_pkg::*;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [TIME_W-1:0] r_in_now;
    logic [TIME_W-1:0] r_in_sleep;

    logic              r_out_valid;
    t_result           r_out;

    logic              w_advance;
    t_cfg              w_cfg;
    t_result           w_result;

    // Evaluate the held operation whenever the output register is free or
    // being emptied this cycle.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    abis_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    abis_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_op        (t_op'(r_in_op)),
        .i_now_ms    (r_in_now),
        .i_sleep_len (r_in_sleep),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    // Input register: take a transfer whenever the slot is free or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op    <= i_s_axis_tuser[OP_W-1:0];
            r_in_now   <= i_s_axis_tdata[TIME_W-1:0];
            r_in_sleep <= i_s_axis_tdata[2*TIME_W-1:TIME_W];
        end
    end

    // Output register: load on advance, drop once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        (M_DATA_W - $bits(t_result))'(0),
        r_out.announce_total,
        r_out.contention_level,
        r_out.interval_now,
        r_out.lapse_before_wake,
        r_out.window_closed,
        r_out.announce,
        r_out.accepted
    };

endmodule

### rtl/core/abis_checker.sv
// Port-level checker for the beacon interval scheduler, bound to the top.
// Depends on abis_pkg and adaptive_beacon_interval_scheduler_macros.svh.
`include "adaptive_beacon_interval_scheduler_macros.svh"

module abis_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [abis_pkg::M_DATA_W-1:0]   o_m_axis_tdata
);
    import abis_pkg::*;

    // Hold a stalled result unchanged.
    `ABIS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed or dropped")

    // Leave reset with the output stage empty.
    `ABIS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid right after reset")

    // Announce or window close only on a tick that took effect.
    `ABIS_ASSERT_IMPLY(a_tick_flags, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[1] || o_m_axis_tdata[2]), o_m_axis_tdata[0] && !o_m_axis_tdata[3], "tick flags without an accepted tick")

    // Drop input ready only while a result waits on a stalled receiver.
    `ABIS_ASSERT_IMPLY(a_ready_stall, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready, "input stalled without a waiting result")

endmodule

bind adaptive_beacon_interval_scheduler abis_checker u_abis_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
